FILE: rtl/core/lmbs_pkg.sv
`timescale 1ns / 1ps

package lmbs_pkg;

	localparam int RATE_FRAC_BITS = 29;
	localparam int POP_FRAC_BITS  = 30;

	localparam int RATE_W = 32;
	localparam int POP_W  = 31;
	localparam int CNT_W  = 13;
	localparam int WARM_W = 16;
	localparam int LOOP_W = 16;
	localparam int PC_W   = 5;
	localparam int ADDR_W = 4;

	localparam logic [RATE_W-1:0] RATE_ONE       = RATE_W'(64'd1 << RATE_FRAC_BITS);
	localparam logic [RATE_W-1:0] RATE_TWO_EIGHT =
		RATE_W'(((64'd14 << RATE_FRAC_BITS) + 64'd2) / 64'd5);
	localparam logic [RATE_W:0]   RATE_FOUR      = (RATE_W+1)'(64'd4 << RATE_FRAC_BITS);
	localparam logic [POP_W-1:0]  POP_ONE        = POP_W'(64'd1 << POP_FRAC_BITS);

	localparam logic [30:0] RST_START_POP = 31'd536870912;
	localparam logic [31:0] RST_RATE_STEP = 32'd2684355;
	localparam logic [12:0] RST_PPR       = 13'd150;
	localparam logic [15:0] RST_WARMUP    = 16'd10000;

	typedef enum logic [1:0] {
		REG_START_POP = 2'd0,
		REG_RATE_STEP = 2'd1,
		REG_PPR       = 2'd2,
		REG_WARMUP    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [POP_W-1:0]  start_population;
		logic [RATE_W-1:0] rate_step;
		logic [CNT_W-1:0]  points_per_rate;
		logic [WARM_W-1:0] warmup_iterations;
	} cfg_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_SEED,
		OP_MUL1,
		OP_MUL2,
		OP_XUPD,
		OP_XEMIT,
		OP_ZERO,
		OP_DIVINIT,
		OP_DIVSTEP,
		OP_DIVDONE,
		OP_EMIT
	} op_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_INPUT,
		C_OUT_BUSY,
		C_R_LE_ONE,
		C_R_LE_TWO8,
		C_CNT_NZ,
		C_LOOP_ZERO,
		C_LOOP_MORE
	} cond_t;

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ctrl_word_t;

	typedef struct packed {
		logic in_valid;
		logic out_blocked;
		logic r_le_one;
		logic r_le_two8;
		logic cnt_nz;
		logic loop_zero;
		logic loop_more;
	} status_t;

	localparam logic [PC_W-1:0] A_WAIT    = 5'd0;
	localparam logic [PC_W-1:0] A_WARM    = 5'd6;
	localparam logic [PC_W-1:0] A_ITER    = 5'd9;
	localparam logic [PC_W-1:0] A_ZERO    = 5'd12;
	localparam logic [PC_W-1:0] A_DIV     = 5'd13;
	localparam logic [PC_W-1:0] A_DIVSTEP = 5'd14;
	localparam logic [PC_W-1:0] A_EMIT    = 5'd31;

	// emit sits at the top address so its fall-through wraps to the wait step
	function automatic ctrl_word_t ucode(input logic [PC_W-1:0] addr);
		ctrl_word_t w;
		w = '{op: OP_NOP, cond: C_ALWAYS, target: A_WAIT};
		case (addr)
			5'd0:  w = '{op: OP_ACCEPT,  cond: C_NO_INPUT,  target: A_WAIT};
			5'd1:  w = '{op: OP_NOP,     cond: C_R_LE_ONE,  target: A_ZERO};
			5'd2:  w = '{op: OP_NOP,     cond: C_R_LE_TWO8, target: A_DIV};
			5'd3:  w = '{op: OP_NOP,     cond: C_CNT_NZ,    target: A_ITER};
			5'd4:  w = '{op: OP_SEED,    cond: C_NEVER,     target: A_WAIT};
			5'd5:  w = '{op: OP_NOP,     cond: C_LOOP_ZERO, target: A_ITER};
			5'd6:  w = '{op: OP_MUL1,    cond: C_NEVER,     target: A_WAIT};
			5'd7:  w = '{op: OP_MUL2,    cond: C_NEVER,     target: A_WAIT};
			5'd8:  w = '{op: OP_XUPD,    cond: C_LOOP_MORE, target: A_WARM};
			5'd9:  w = '{op: OP_MUL1,    cond: C_NEVER,     target: A_WAIT};
			5'd10: w = '{op: OP_MUL2,    cond: C_NEVER,     target: A_WAIT};
			5'd11: w = '{op: OP_XEMIT,   cond: C_ALWAYS,    target: A_EMIT};
			5'd12: w = '{op: OP_ZERO,    cond: C_ALWAYS,    target: A_EMIT};
			5'd13: w = '{op: OP_DIVINIT, cond: C_NEVER,     target: A_WAIT};
			5'd14: w = '{op: OP_DIVSTEP, cond: C_LOOP_MORE, target: A_DIVSTEP};
			5'd15: w = '{op: OP_DIVDONE, cond: C_ALWAYS,    target: A_EMIT};
			5'd31: w = '{op: OP_EMIT,    cond: C_OUT_BUSY,  target: A_EMIT};
			default: w = '{op: OP_NOP,   cond: C_ALWAYS,    target: A_WAIT};
		endcase
		return w;
	endfunction

endpackage

FILE: rtl/core/lmbs_useq.sv
`timescale 1ns / 1ps

module lmbs_useq
	import lmbs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  status_t    status,
	output ctrl_word_t ctrl
);

	logic [PC_W-1:0] pc_q;
	logic            take;

	assign ctrl = ucode(pc_q);

	always_comb begin
		case (ctrl.cond)
			C_NEVER:     take = 1'b0;
			C_ALWAYS:    take = 1'b1;
			C_NO_INPUT:  take = !status.in_valid;
			C_OUT_BUSY:  take = status.out_blocked;
			C_R_LE_ONE:  take = status.r_le_one;
			C_R_LE_TWO8: take = status.r_le_two8;
			C_CNT_NZ:    take = status.cnt_nz;
			C_LOOP_ZERO: take = status.loop_zero;
			C_LOOP_MORE: take = status.loop_more;
			default:     take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= A_WAIT;
		end else if (take) begin
			pc_q <= ctrl.target;
		end else begin
			pc_q <= pc_q + PC_W'(1);
		end
	end

endmodule

FILE: rtl/core/lmbs_dpath.sv
`timescale 1ns / 1ps

module lmbs_dpath
	import lmbs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_word_t        ctrl,
	input  cfg_t              cfg,
	input  logic              in_valid,
	input  logic              restart,
	input  logic              out_stall,
	output status_t           status,
	output logic [RATE_W-1:0] growth_rate,
	output logic [POP_W-1:0]  population,
	output logic              sweep_last,
	output logic              out_valid
);

	localparam int P1_W = 2 * POP_W;
	localparam int T_W  = POP_FRAC_BITS;
	localparam int P2_W = RATE_W + T_W;
	localparam int Y_W  = P2_W - RATE_FRAC_BITS;
	localparam int Q_W  = POP_FRAC_BITS;

	logic [RATE_W-1:0] rate_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [POP_W-1:0]  x_q;
	logic [P1_W-1:0]   p1_q;
	logic [P2_W-1:0]   p2_q;
	logic [LOOP_W-1:0] loop_q;
	logic [RATE_W-1:0] rem_q;
	logic [Q_W-1:0]    quo_q;
	logic [POP_W-1:0]  pop_q;
	logic              adv_q;

	logic [RATE_W-1:0] growth_rate_q;
	logic [POP_W-1:0]  population_q;
	logic              sweep_last_q;
	logic              out_valid_q;

	logic [POP_W-1:0]  one_minus_x;
	logic [T_W-1:0]    t;
	logic [Y_W-1:0]    y;
	logic [POP_W-1:0]  ysat;
	logic [POP_W-1:0]  seed;
	logic [RATE_W:0]   sh;
	logic [RATE_W:0]   diff;
	logic              ge;
	logic [CNT_W-1:0]  cnt_inc;
	logic [CNT_W-1:0]  limit;
	logic              hit;
	logic [RATE_W-1:0] step;
	logic [RATE_W:0]   nxt;
	logic              wrap;
	logic              fire_accept;
	logic              fire_emit;
	logic              out_blocked;

	assign out_blocked = out_valid_q && out_stall;
	assign fire_accept = (ctrl.op == OP_ACCEPT) && in_valid;
	assign fire_emit   = (ctrl.op == OP_EMIT) && !out_blocked;

	assign one_minus_x = POP_ONE - x_q;
	assign t           = p1_q[POP_FRAC_BITS +: T_W];
	assign y           = p2_q[RATE_FRAC_BITS +: Y_W];
	assign ysat        = (y > Y_W'(POP_ONE)) ? POP_ONE : y[POP_W-1:0];
	assign seed        = (cfg.start_population > POP_ONE) ? POP_ONE : cfg.start_population;

	assign sh   = {rem_q, 1'b0};
	assign ge   = sh >= {1'b0, rate_q};
	assign diff = sh - {1'b0, rate_q};

	assign cnt_inc = cnt_q + CNT_W'(1);
	assign limit   = (cfg.points_per_rate == '0) ? CNT_W'(1) : cfg.points_per_rate;
	assign hit     = cnt_inc >= limit;

	assign step = (cfg.rate_step == '0) ? RATE_W'(1) : cfg.rate_step;
	assign nxt  = {1'b0, rate_q} + {1'b0, step};
	assign wrap = nxt > RATE_FOUR;

	assign status = '{
		in_valid:    in_valid,
		out_blocked: out_blocked,
		r_le_one:    rate_q <= RATE_ONE,
		r_le_two8:   rate_q <= RATE_TWO_EIGHT,
		cnt_nz:      cnt_q != '0,
		loop_zero:   loop_q == '0,
		loop_more:   loop_q != LOOP_W'(1)
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q      <= '0;
			cnt_q       <= '0;
			adv_q       <= 1'b0;
			loop_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire_accept && restart) begin
				rate_q <= '0;
				cnt_q  <= '0;
			end
			case (ctrl.op)
				OP_SEED:    loop_q <= LOOP_W'(cfg.warmup_iterations);
				OP_XUPD:    loop_q <= loop_q - LOOP_W'(1);
				OP_DIVINIT: loop_q <= LOOP_W'(Q_W);
				OP_DIVSTEP: loop_q <= loop_q - LOOP_W'(1);
				OP_ZERO,
				OP_DIVDONE: adv_q  <= 1'b1;
				OP_XEMIT: begin
					adv_q <= hit;
					cnt_q <= hit ? '0 : cnt_inc;
				end
				default: ;
			endcase
			if (fire_emit && adv_q) begin
				if (wrap) begin
					rate_q <= '0;
					cnt_q  <= '0;
				end else begin
					rate_q <= nxt[RATE_W-1:0];
				end
			end
			if (fire_emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_SEED:    x_q  <= seed;
			OP_MUL1:    p1_q <= x_q * one_minus_x;
			OP_MUL2:    p2_q <= rate_q * t;
			OP_XUPD:    x_q  <= ysat;
			OP_XEMIT: begin
				x_q   <= ysat;
				pop_q <= ysat;
			end
			OP_ZERO:    pop_q <= '0;
			OP_DIVINIT: begin
				rem_q <= RATE_W'(64'd1 << RATE_FRAC_BITS);
				quo_q <= '0;
			end
			OP_DIVSTEP: begin
				rem_q <= ge ? diff[RATE_W-1:0] : sh[RATE_W-1:0];
				quo_q <= {quo_q[Q_W-2:0], ge};
			end
			OP_DIVDONE: pop_q <= POP_ONE - POP_W'(quo_q);
			default: ;
		endcase
		if (fire_emit) begin
			growth_rate_q <= rate_q;
			population_q  <= pop_q;
			sweep_last_q  <= adv_q && wrap;
		end
	end

	assign growth_rate = growth_rate_q;
	assign population  = population_q;
	assign sweep_last  = sweep_last_q;
	assign out_valid   = out_valid_q;

endmodule

FILE: rtl/core/logistic_map_bifurcation_sweep_core.sv
`timescale 1ns / 1ps
// Per input beat: zero population for rate <= 1.0, 1-1/r for rates up to 2.8
// (bit-serial divider, one quotient bit per cycle), else the multiply loop for a chaotic rate,
// with the warm-up iterations first on the first point of a rate (loop steps: MUL1, MUL2, update).
// One item at a time; the core is ready for the next beat in the cycle after the result is registered.
// arst_n (async, active low) clears the sequencer, the rate, the count and out_valid;
// configuration registers return to their defaults.

module logistic_map_bifurcation_sweep_core
	import lmbs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              restart,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [RATE_W-1:0] growth_rate,
	output logic [POP_W-1:0]  population,
	output logic              sweep_last
);

	cfg_t       cfg_q;
	ctrl_word_t ctrl;
	status_t    status;
	reg_idx_t   idx;
	logic       wr;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_population  <= RST_START_POP;
			cfg_q.rate_step         <= RST_RATE_STEP;
			cfg_q.points_per_rate   <= RST_PPR;
			cfg_q.warmup_iterations <= RST_WARMUP;
		end else if (wr) begin
			case (idx)
				REG_START_POP: cfg_q.start_population  <= pwdata[POP_W-1:0];
				REG_RATE_STEP: cfg_q.rate_step         <= pwdata[RATE_W-1:0];
				REG_PPR:       cfg_q.points_per_rate   <= pwdata[CNT_W-1:0];
				REG_WARMUP:    cfg_q.warmup_iterations <= pwdata[WARM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_START_POP: prdata = 32'(cfg_q.start_population);
			REG_RATE_STEP: prdata = 32'(cfg_q.rate_step);
			REG_PPR:       prdata = 32'(cfg_q.points_per_rate);
			REG_WARMUP:    prdata = 32'(cfg_q.warmup_iterations);
			default:       prdata = '0;
		endcase
	end

	assign in_stall = ctrl.op != OP_ACCEPT;

	lmbs_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	lmbs_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.restart     (restart),
		.out_stall   (out_stall),
		.status      (status),
		.growth_rate (growth_rate),
		.population  (population),
		.sweep_last  (sweep_last),
		.out_valid   (out_valid)
	);

endmodule

FILE: rtl/core/lmbs_checker.sv
`timescale 1ns / 1ps

module lmbs_checker
	import lmbs_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [RATE_W-1:0] growth_rate,
	input logic [POP_W-1:0]  population,
	input logic              sweep_last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(growth_rate)
			&& $stable(population) && $stable(sweep_last))
		else $error("result beat changed while stalled");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, growth_rate} <= RATE_FOUR) && (population <= POP_ONE))
		else $error("result out of range");

	a_low_rate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (growth_rate <= RATE_ONE) |-> population == '0)
		else $error("nonzero population at rate <= 1");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second beat taken while item in flight");

endmodule

bind logistic_map_bifurcation_sweep_core lmbs_checker u_lmbs_checker (.*);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import lmbs_pkg::*;

	typedef struct packed {
		logic [RATE_W-1:0] growth_rate;
		logic [POP_W-1:0]  population;
		logic              sweep_last;
	} point_t;

	localparam logic [31:0] STEP_3P5 = 32'd1879048192;
	localparam logic [31:0] STEP_3P7 = 32'd1986422374;
	localparam logic [31:0] STEP_4P0 = 32'h8000_0000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              restart = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [RATE_W-1:0] growth_rate;
	logic [POP_W-1:0]  population;
	logic              sweep_last;

	logistic_map_bifurcation_sweep_core dut (.*);

	// model of the sweep
	cfg_t              sweep_cfg;
	logic [63:0]       sweep_rate;
	logic [63:0]       sweep_pop;
	logic [CNT_W-1:0]  sweep_cnt;
	point_t            pending_points[$];

	bit idle_on = 1'b1;
	int hold_cycles = 0;
	int err_cnt = 0;
	int n_checked = 0;
	int n_zero = 0;
	int n_fixed = 0;
	int n_chaos = 0;
	int n_ends = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic logic [63:0] logistic_iter(input logic [63:0] r, input logic [63:0] x);
		logic [63:0] t;
		logic [63:0] y;
		t = (x * (64'(POP_ONE) - x)) >> POP_FRAC_BITS;
		y = (r * t) >> RATE_FRAC_BITS;
		return (y > 64'(POP_ONE)) ? 64'(POP_ONE) : y;
	endfunction

	function automatic point_t sweep_point(input logic rs);
		logic [63:0] r;
		logic [63:0] x;
		logic [63:0] nxt;
		logic [63:0] stp;
		int unsigned lim;
		logic        adv;
		point_t      p;
		adv = 1'b1;
		p.sweep_last = 1'b0;
		if (rs) begin
			sweep_rate = '0;
			sweep_cnt = '0;
		end
		r = sweep_rate;
		if (r <= 64'(RATE_ONE)) begin
			p.population = '0;
			n_zero++;
		end else if (r <= 64'(RATE_TWO_EIGHT)) begin
			p.population = POP_W'(64'(POP_ONE) - ((64'(POP_ONE) << RATE_FRAC_BITS) / r));
			n_fixed++;
		end else begin
			if (sweep_cnt == 0) begin
				x = 64'(sweep_cfg.start_population);
				if (x > 64'(POP_ONE))
					x = 64'(POP_ONE);
				repeat (sweep_cfg.warmup_iterations) x = logistic_iter(r, x);
				sweep_pop = x;
			end
			sweep_pop = logistic_iter(r, sweep_pop);
			p.population = POP_W'(sweep_pop);
			lim = (sweep_cfg.points_per_rate == 0) ? 1 : sweep_cfg.points_per_rate;
			sweep_cnt = sweep_cnt + 1'b1;
			if (sweep_cnt >= lim)
				sweep_cnt = '0;
			else
				adv = 1'b0;
			n_chaos++;
		end
		if (adv) begin
			stp = (sweep_cfg.rate_step == 0) ? 64'd1 : 64'(sweep_cfg.rate_step);
			nxt = r + stp;
			if (nxt > 64'(RATE_FOUR)) begin
				p.sweep_last = 1'b1;
				sweep_rate = '0;
				sweep_cnt = '0;
				n_ends++;
			end else begin
				sweep_rate = nxt;
			end
		end
		p.growth_rate = r[RATE_W-1:0];
		return p;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		err_cnt++;
		if (err_cnt <= 100)
			$display("ERROR @%0t %s: got %0h want %0h", $time, what, got, want);
	endtask

	task automatic check_point();
		point_t e;
		if (pending_points.size() == 0) begin
			report_mismatch("result beat with nothing pending", 64'(growth_rate), 64'd0);
			return;
		end
		e = pending_points.pop_front();
		n_checked++;
		if (growth_rate !== e.growth_rate)
			report_mismatch("growth_rate", 64'(growth_rate), 64'(e.growth_rate));
		if (population !== e.population)
			report_mismatch("population", 64'(population), 64'(e.population));
		if (sweep_last !== e.sweep_last)
			report_mismatch("sweep_last", 64'(sweep_last), 64'(e.sweep_last));
	endtask

	// result side: random stall per beat, long hold on request
	initial begin : result_sink
		int n;
		forever begin
			n = idle_on ? $urandom_range(0, 12) : 0;
			if (hold_cycles > 0) begin
				n = hold_cycles;
				hold_cycles = 0;
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			check_point();
		end
	end

	task automatic send_beat(input logic rs);
		int gap;
		gap = idle_on ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		restart <= rs;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_points.push_back(sweep_point(rs));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_points.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_START_POP: sweep_cfg.start_population = val[POP_W-1:0];
			REG_RATE_STEP: sweep_cfg.rate_step = val;
			REG_PPR:       sweep_cfg.points_per_rate = val[CNT_W-1:0];
			REG_WARMUP:    sweep_cfg.warmup_iterations = val[WARM_W-1:0];
			default: ;
		endcase
	endtask

	task automatic test_reset_defaults();
		send_beat(1'b0);
		send_beat(1'b0);
		drain();
		write_reg(REG_RATE_STEP, STEP_3P7);
		send_beat(1'b1);
		send_beat(1'b0);
		send_beat(1'b0);
		drain();
	endtask

	task automatic test_region_edges();
		write_reg(REG_WARMUP, 32'd0);
		write_reg(REG_PPR, 32'd1);
		write_reg(REG_START_POP, 32'h7FFF_FFFF);
		write_reg(REG_RATE_STEP, 32'(RATE_TWO_EIGHT));
		send_beat(1'b1);
		send_beat(1'b0);
		drain();
		write_reg(REG_RATE_STEP, 32'(RATE_TWO_EIGHT) + 32'd1);
		send_beat(1'b0);
		send_beat(1'b0);
		drain();
		write_reg(REG_START_POP, 32'(POP_ONE));
		write_reg(REG_RATE_STEP, STEP_4P0);
		send_beat(1'b0);
		send_beat(1'b0);
		drain();
		write_reg(REG_START_POP, 32'd0);
		write_reg(REG_RATE_STEP, 32'(RATE_ONE) + 32'd1);
		repeat (4) send_beat(1'b0);
		drain();
		write_reg(REG_RATE_STEP, 32'd0);
		send_beat(1'b0);
		send_beat(1'b0);
		drain();
		write_reg(REG_RATE_STEP, 32'd1);
		send_beat(1'b0);
		drain();
	endtask

	task automatic test_count_limits();
		write_reg(REG_RATE_STEP, STEP_3P5);
		write_reg(REG_START_POP, 32'd322122547);
		write_reg(REG_PPR, 32'd4096);
		write_reg(REG_WARMUP, 32'd65535);
		send_beat(1'b1);
		send_beat(1'b0);
		send_beat(1'b0);
		drain();
		// new start and warm-up must wait for the next chaotic rate
		write_reg(REG_WARMUP, 32'd3);
		write_reg(REG_START_POP, 32'h1000_0000);
		send_beat(1'b0);
		drain();
		// count already past the lowered limit: this point closes the rate
		write_reg(REG_PPR, 32'd2);
		send_beat(1'b0);
		drain();
		write_reg(REG_PPR, 32'd0);
		send_beat(1'b0);
		send_beat(1'b0);
		drain();
	endtask

	task automatic test_backpressure();
		write_reg(REG_RATE_STEP, 32'h1000_0000);
		write_reg(REG_WARMUP, 32'd2);
		write_reg(REG_PPR, 32'd3);
		write_reg(REG_START_POP, 32'd429496730);
		idle_on = 1'b0;
		hold_cycles = 400;
		send_beat(1'b1);
		repeat (11) send_beat(1'b0);
		drain();
		idle_on = 1'b1;
	endtask

	task automatic test_random();
		logic [31:0] v;
		for (int ph = 0; ph < 17; ph++) begin
			drain();
			case ($urandom_range(0, 9))
				0: v = $urandom();
				1: v = $urandom_range(1, 32'h0010_0000);
				2: v = STEP_4P0;
				default: v = $urandom_range(32'h0400_0000, 32'h4000_0000);
			endcase
			write_reg(REG_RATE_STEP, v);
			case ($urandom_range(0, 5))
				0: v = $urandom() & 32'h7FFF_FFFF;
				1: v = 32'(POP_ONE);
				default: v = $urandom_range(0, 32'(POP_ONE));
			endcase
			write_reg(REG_START_POP, v);
			v = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 300) : $urandom_range(0, 12);
			write_reg(REG_WARMUP, v);
			case ($urandom_range(0, 11))
				0: v = 32'd0;
				1: v = $urandom_range(7, 40);
				2: v = 32'd8191;
				default: v = $urandom_range(1, 6);
			endcase
			write_reg(REG_PPR, v);
			idle_on = (ph % 4) != 3;
			for (int i = 0; i < 50; i++)
				send_beat($urandom_range(0, 15) == 0);
		end
		drain();
		idle_on = 1'b1;
	endtask

	initial begin
		sweep_cfg = '{start_population: RST_START_POP, rate_step: RST_RATE_STEP,
			points_per_rate: RST_PPR, warmup_iterations: RST_WARMUP};
		sweep_rate = '0;
		sweep_pop = '0;
		sweep_cnt = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);
		test_reset_defaults();
		test_region_edges();
		test_count_limits();
		test_backpressure();
		test_random();
		while (pending_points.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("Checked %0d sweep points: %0d zero, %0d on the 1-1/r curve, %0d chaotic",
			n_checked, n_zero, n_fixed, n_chaos);
		$display("Sweeps closed: %0d; config phases incl. a 65535-iteration warm-up and a long hold",
			n_ends);
		if (err_cnt == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
